FILE: hw/rtl/ccs_pkg.sv
// Shared types, constants and helper functions for the contour cell segmenter.
// Used by every module under hw/rtl; depends on nothing else.
package ccs_pkg;

  // ---------------------------------------------------------------- payload
  typedef struct packed {
    logic signed [31:0] height_sw;
    logic signed [31:0] height_se;
    logic signed [31:0] height_ne;
    logic signed [31:0] height_nw;
    logic signed [31:0] x_low;
    logic signed [31:0] x_high;
    logic signed [31:0] y_low;
    logic signed [31:0] y_high;
  } cell_t;

  typedef struct packed {
    logic signed [31:0] seg_x_start;
    logic signed [31:0] seg_y_start;
    logic signed [31:0] seg_x_end;
    logic signed [31:0] seg_y_end;
    logic [1:0]         level_index;
    logic               last_segment;
  } seg_t;

  // ------------------------------------------------------ config registers
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CFG_LEVEL_COUNT = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_LEVEL_ZERO  = 3'd1;

  // --------------------------------------------------------- internal widths
  // relative heights: 4*(corner-level) or sum of four differences
  typedef logic signed [34:0] hgt_t;
  // positions in half-LSB units, offset by 2^33 so they are never negative
  localparam int unsigned UposW = 34;
  typedef logic [UposW-1:0] upos_t;
  // Q16.16 value before saturation
  typedef logic signed [34:0] qwide_t;

  localparam logic [34:0] HalfOfs = 35'h2_0000_0000;
  localparam qwide_t      QOfs    = 35'sh1_0000_0000;

  // crossing unit sizes
  localparam int unsigned MagW   = 36;
  localparam int unsigned SumW   = 37;
  localparam int unsigned DivW   = 38;
  localparam int unsigned AccW   = 72;
  localparam int unsigned QuoW   = 34;
  localparam int unsigned StepCntW = 6;

  // ----------------------------------------------------- case classification
  localparam logic [1:0] SH_BELOW = 2'd0;
  localparam logic [1:0] SH_ON    = 2'd1;
  localparam logic [1:0] SH_ABOVE = 2'd2;

  // triangle-local vertices: first corner, centre, next corner
  localparam logic [1:0] TV_FIRST  = 2'd0;
  localparam logic [1:0] TV_CENTRE = 2'd1;
  localparam logic [1:0] TV_NEXT   = 2'd2;

  typedef enum logic [3:0] {
    SC_NONE,
    SC_F_C,      // first -> centre
    SC_C_N,      // centre -> next
    SC_N_F,      // next -> first
    SC_F_XCN,    // first -> crossing(centre, next)
    SC_C_XNF,    // centre -> crossing(next, first)
    SC_N_XFC,    // next -> crossing(first, centre)
    SC_XFC_XCN,
    SC_XCN_XNF,
    SC_XNF_XFC
  } seg_case_e;

  typedef seg_case_e case_row_t [3];
  typedef case_row_t case_plane_t [3];

  localparam case_plane_t CaseTable [3] = '{
    '{ '{SC_NONE, SC_NONE, SC_XCN_XNF},
       '{SC_NONE, SC_C_N, SC_C_XNF},
       '{SC_XFC_XCN, SC_N_XFC, SC_XNF_XFC} },
    '{ '{SC_NONE, SC_N_F, SC_F_XCN},
       '{SC_F_C, SC_N_F, SC_F_C},
       '{SC_F_XCN, SC_N_F, SC_NONE} },
    '{ '{SC_XNF_XFC, SC_N_XFC, SC_XFC_XCN},
       '{SC_C_XNF, SC_C_N, SC_NONE},
       '{SC_XCN_XNF, SC_NONE, SC_NONE} }
  };

  // one segment end: a vertex (pa) or the crossing between pa and pb
  typedef struct packed {
    logic       xing;
    logic [1:0] pa;
    logic [1:0] pb;
  } ep_sel_t;

  typedef struct packed {
    ep_sel_t st;
    ep_sel_t en;
  } seg_sel_t;

  // ------------------------------------------------------------- queue item
  typedef struct packed {
    logic  xing;
    hgt_t  ha;
    hgt_t  hb;
    upos_t uxa;
    upos_t uya;
    upos_t uxb;
    upos_t uyb;
  } endpoint_t;

  typedef struct packed {
    endpoint_t  ep_start;
    endpoint_t  ep_end;
    logic [1:0] level;
    logic       last;
  } job_t;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueueAw    = 1;

  // crossing unit request
  typedef struct packed {
    hgt_t  ha;
    hgt_t  hb;
    upos_t ua;
    upos_t ub;
  } xreq_t;

  // ---------------------------------------------------------- state machines
  typedef enum logic [1:0] {F_IDLE, F_LEVEL, F_TRI, F_FLUSH} front_state_e;
  typedef enum logic [1:0] {B_IDLE, B_EVAL, B_WAIT, B_OUT} back_state_e;
  typedef enum logic [2:0] {X_IDLE, X_SUM, X_MUL, X_ADD, X_DIV, X_DONE} xing_state_e;

  // --------------------------------------------------------------- functions
  function automatic seg_sel_t seg_select(seg_case_e c);
    seg_sel_t s;
    s = '0;
    case (c)
      SC_F_C:     begin s.st.pa = TV_FIRST;  s.en.pa = TV_CENTRE; end
      SC_C_N:     begin s.st.pa = TV_CENTRE; s.en.pa = TV_NEXT;   end
      SC_N_F:     begin s.st.pa = TV_NEXT;   s.en.pa = TV_FIRST;  end
      SC_F_XCN: begin
        s.st.pa = TV_FIRST;
        s.en = '{xing: 1'b1, pa: TV_CENTRE, pb: TV_NEXT};
      end
      SC_C_XNF: begin
        s.st.pa = TV_CENTRE;
        s.en = '{xing: 1'b1, pa: TV_NEXT, pb: TV_FIRST};
      end
      SC_N_XFC: begin
        s.st.pa = TV_NEXT;
        s.en = '{xing: 1'b1, pa: TV_FIRST, pb: TV_CENTRE};
      end
      SC_XFC_XCN: begin
        s.st = '{xing: 1'b1, pa: TV_FIRST, pb: TV_CENTRE};
        s.en = '{xing: 1'b1, pa: TV_CENTRE, pb: TV_NEXT};
      end
      SC_XCN_XNF: begin
        s.st = '{xing: 1'b1, pa: TV_CENTRE, pb: TV_NEXT};
        s.en = '{xing: 1'b1, pa: TV_NEXT, pb: TV_FIRST};
      end
      SC_XNF_XFC: begin
        s.st = '{xing: 1'b1, pa: TV_NEXT, pb: TV_FIRST};
        s.en = '{xing: 1'b1, pa: TV_FIRST, pb: TV_CENTRE};
      end
      default: s = '0;
    endcase
    return s;
  endfunction

  function automatic logic [1:0] sign_class(hgt_t h);
    logic [1:0] r;
    if (h > 35'sd0) r = SH_ABOVE;
    else if (h < 35'sd0) r = SH_BELOW;
    else r = SH_ON;
    return r;
  endfunction

  // half-LSB offset position to Q16.16, ties toward plus infinity
  function automatic qwide_t half_to_q(upos_t u);
    logic [34:0] t;
    t = {1'b0, u} + 35'd1;
    return $signed({1'b0, t[34:1]}) - QOfs;
  endfunction

  function automatic logic signed [31:0] sat_q32(qwide_t v);
    logic signed [31:0] r;
    if (v > 35'sd2147483647) r = 32'sh7fff_ffff;
    else if (v < -35'sd2147483648) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic [MagW-1:0] mag36(hgt_t h);
    logic [MagW-1:0] e;
    e = {h[34], h};
    return h[34] ? (~e + 36'd1) : e;
  endfunction

endpackage

FILE: hw/rtl/contour_cell_segmenter_top.sv
// Top level of the contour cell segmenter: front end, job queue, back end
// and crossing unit. Uses ccs_pkg and the ccs_* modules.
//
//  port group   direction  handshake                 payload
//  in_*         input      in_valid_i / in_stall_o   cell_t  (one grid cell)
//  out_*        output     out_valid_o / out_stall_i seg_t   (one segment)
//  cfg_*        input      cfg_we_i                  cfg_index_i, cfg_data_i
//
// One cell is taken at a time; the front walks the levels and, for each level in
// range, the four triangles, and is ready again once its last job has entered the
// queue. The back end resolves each vertex coordinate directly and each crossing
// coordinate in the single shared crossing unit (34 multiply steps, 34 divide
// steps), so the crossing unit sets the sustained rate.
// Reset is asynchronous and active low; level_count resets to 1, levels to 0.
// An output stall holds the result register; the queue lets the front run on.
module contour_cell_segmenter_top import ccs_pkg::*; #(
  parameter int unsigned MAX_LEVELS = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  cell_t              in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output seg_t               out_item_o
);

  logic   q_push, q_ready, q_pop, q_valid;
  job_t   q_wdata, q_rdata;
  logic   x_start, x_done;
  xreq_t  x_req;
  qwide_t x_result;

  ccs_front #(.MAX_LEVELS(MAX_LEVELS)) u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .in_item_i,
    .q_push_o(q_push), .q_data_o(q_wdata), .q_ready_i(q_ready)
  );

  ccs_queue u_queue (
    .clk_i, .rst_ni,
    .push_i(q_push), .push_data_i(q_wdata), .ready_o(q_ready),
    .pop_i(q_pop), .pop_data_o(q_rdata), .valid_o(q_valid)
  );

  ccs_xing u_xing (
    .clk_i, .rst_ni, .start_i(x_start), .req_i(x_req),
    .done_o(x_done), .result_o(x_result)
  );

  ccs_back u_back (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_data_i(q_rdata), .q_pop_o(q_pop),
    .x_start_o(x_start), .x_req_o(x_req), .x_done_i(x_done), .x_result_i(x_result),
    .out_valid_o, .out_stall_i, .out_item_o
  );

endmodule

FILE: hw/rtl/ccs_front.sv
// Front end: configuration registers, cell intake, level and triangle walk.
// Classifies each triangle and pushes one job per segment. Uses ccs_pkg.
module ccs_front import ccs_pkg::*; #(
  parameter int unsigned MAX_LEVELS = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  cell_t              in_item_i,
  output logic               q_push_o,
  output job_t               q_data_o,
  input  logic               q_ready_i
);

  localparam int unsigned KW = $clog2(MAX_LEVELS + 1);
  localparam int unsigned IW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;

  // configuration
  logic [2:0]         level_count_q;
  logic signed [31:0] lv_q [MAX_LEVELS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_count_q <= 3'd1;
      for (int i = 0; i < MAX_LEVELS; i++) lv_q[i] <= '0;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_LEVEL_COUNT) level_count_q <= cfg_data_i[2:0];
      for (int i = 0; i < MAX_LEVELS; i++) begin
        if (cfg_index_i == CfgIdxW'(CFG_LEVEL_ZERO + i)) lv_q[i] <= cfg_data_i;
      end
    end
  end

  // cell registers
  logic signed [31:0] d_q [1:4];
  upos_t              ux_q [0:4];
  upos_t              uy_q [0:4];
  logic signed [31:0] dmin_q, dmax_q;
  hgt_t               h_q [0:4];

  front_state_e state_q, state_d;
  logic [KW-1:0] k_q;
  logic [1:0]    m_q;
  logic          pend_valid_q;
  job_t          pend_q;

  // intake arithmetic
  function automatic upos_t vert_u(logic signed [31:0] x);
    logic [34:0] t;
    t = {x[31], x[31], x, 1'b0} + HalfOfs;
    return t[33:0];
  endfunction

  function automatic upos_t cent_u(logic signed [31:0] a, logic signed [31:0] b);
    logic [34:0] t;
    t = {{3{a[31]}}, a} + {{3{b[31]}}, b} + HalfOfs;
    return t[33:0];
  endfunction

  logic signed [31:0] min_a, min_b, max_a, max_b, dmin_in, dmax_in;
  always_comb begin
    min_a = (in_item_i.height_sw < in_item_i.height_se) ? in_item_i.height_sw
                                                        : in_item_i.height_se;
    min_b = (in_item_i.height_ne < in_item_i.height_nw) ? in_item_i.height_ne
                                                        : in_item_i.height_nw;
    max_a = (in_item_i.height_sw > in_item_i.height_se) ? in_item_i.height_sw
                                                        : in_item_i.height_se;
    max_b = (in_item_i.height_ne > in_item_i.height_nw) ? in_item_i.height_ne
                                                        : in_item_i.height_nw;
    dmin_in = (min_a < min_b) ? min_a : min_b;
    dmax_in = (max_a > max_b) ? max_a : max_b;
  end

  // level checks
  logic [2:0]         nlev, nlev_m1;
  logic signed [31:0] lv_cur, lv_last;
  logic               cull, lv_end, lv_in;
  always_comb begin
    nlev    = (level_count_q > 3'(MAX_LEVELS)) ? 3'(MAX_LEVELS) : level_count_q;
    nlev_m1 = nlev - 3'd1;
    lv_last = lv_q[nlev_m1[IW-1:0]];
    lv_cur  = lv_q[k_q[IW-1:0]];
    cull    = (nlev == 3'd0) || (dmax_q < lv_q[0]) || (dmin_q > lv_last);
    lv_end  = (3'(k_q) == nlev);
    lv_in   = !((lv_cur < dmin_q) || (lv_cur > dmax_q));
  end

  // relative heights for the current level
  logic signed [32:0] diff [1:4];
  hgt_t               h_new [0:4];
  always_comb begin
    h_new[0] = '0;
    for (int i = 1; i <= 4; i++) begin
      diff[i]  = {d_q[i][31], d_q[i]} - {lv_cur[31], lv_cur};
      h_new[i] = {diff[i], 2'b00};
      h_new[0] = h_new[0] + {{2{diff[i][32]}}, diff[i]};
    end
  end

  // current triangle: first corner, centre, next corner
  hgt_t  tri_h [3];
  upos_t tri_ux [3];
  upos_t tri_uy [3];
  always_comb begin
    tri_h[1] = h_q[0]; tri_ux[1] = ux_q[0]; tri_uy[1] = uy_q[0];
    case (m_q)
      2'd0: begin
        tri_h[0] = h_q[1]; tri_ux[0] = ux_q[1]; tri_uy[0] = uy_q[1];
        tri_h[2] = h_q[2]; tri_ux[2] = ux_q[2]; tri_uy[2] = uy_q[2];
      end
      2'd1: begin
        tri_h[0] = h_q[2]; tri_ux[0] = ux_q[2]; tri_uy[0] = uy_q[2];
        tri_h[2] = h_q[3]; tri_ux[2] = ux_q[3]; tri_uy[2] = uy_q[3];
      end
      2'd2: begin
        tri_h[0] = h_q[3]; tri_ux[0] = ux_q[3]; tri_uy[0] = uy_q[3];
        tri_h[2] = h_q[4]; tri_ux[2] = ux_q[4]; tri_uy[2] = uy_q[4];
      end
      default: begin
        tri_h[0] = h_q[4]; tri_ux[0] = ux_q[4]; tri_uy[0] = uy_q[4];
        tri_h[2] = h_q[1]; tri_ux[2] = ux_q[1]; tri_uy[2] = uy_q[1];
      end
    endcase
  end

  seg_case_e code;
  seg_sel_t  sel;
  job_t      new_job;

  function automatic endpoint_t make_ep(ep_sel_t s, hgt_t th [3], upos_t tx [3],
                                        upos_t ty [3]);
    endpoint_t e;
    e.xing = s.xing;
    e.ha   = th[s.pa];
    e.hb   = th[s.pb];
    e.uxa  = tx[s.pa];
    e.uya  = ty[s.pa];
    e.uxb  = tx[s.pb];
    e.uyb  = ty[s.pb];
    return e;
  endfunction

  always_comb begin
    code = CaseTable[sign_class(tri_h[0])][sign_class(tri_h[1])][sign_class(tri_h[2])];
    sel  = seg_select(code);
    new_job.ep_start = make_ep(sel.st, tri_h, tri_ux, tri_uy);
    new_job.ep_end   = make_ep(sel.en, tri_h, tri_ux, tri_uy);
    new_job.level    = 2'(k_q);
    new_job.last     = 1'b0;
  end

  logic can_take, has_seg;
  assign can_take = !pend_valid_q || q_ready_i;
  assign has_seg  = (code != SC_NONE);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      F_IDLE:  if (in_valid_i) state_d = F_LEVEL;
      F_LEVEL: begin
        if (cull || lv_end) state_d = F_FLUSH;
        else if (lv_in) state_d = F_TRI;
      end
      F_TRI:   if ((!has_seg || can_take) && m_q == 2'd3) state_d = F_LEVEL;
      F_FLUSH: if (!pend_valid_q || q_ready_i) state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  // control outputs
  logic accept, lv_skip, lv_load, tri_adv, tri_new, flush_push;
  always_comb begin
    in_stall_o = (state_q != F_IDLE);
    accept     = (state_q == F_IDLE) && in_valid_i;
    lv_skip    = (state_q == F_LEVEL) && !cull && !lv_end && !lv_in;
    lv_load    = (state_q == F_LEVEL) && !cull && !lv_end && lv_in;
    tri_adv    = (state_q == F_TRI) && (!has_seg || can_take);
    tri_new    = tri_adv && has_seg;
    flush_push = (state_q == F_FLUSH) && pend_valid_q && q_ready_i;
    q_push_o   = (tri_new && pend_valid_q) || flush_push;
    q_data_o   = pend_q;
    q_data_o.last = (state_q == F_FLUSH);
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= F_IDLE;
      k_q          <= '0;
      m_q          <= '0;
      pend_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) k_q <= '0;
      else if (lv_skip || (tri_adv && m_q == 2'd3)) k_q <= k_q + KW'(1);
      if (lv_load) m_q <= '0;
      else if (tri_adv) m_q <= m_q + 2'd1;
      if (tri_new) pend_valid_q <= 1'b1;
      else if (flush_push) pend_valid_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      d_q[1]  <= in_item_i.height_sw;
      d_q[2]  <= in_item_i.height_se;
      d_q[3]  <= in_item_i.height_ne;
      d_q[4]  <= in_item_i.height_nw;
      dmin_q  <= dmin_in;
      dmax_q  <= dmax_in;
      ux_q[0] <= cent_u(in_item_i.x_low, in_item_i.x_high);
      uy_q[0] <= cent_u(in_item_i.y_low, in_item_i.y_high);
      ux_q[1] <= vert_u(in_item_i.x_low);  uy_q[1] <= vert_u(in_item_i.y_low);
      ux_q[2] <= vert_u(in_item_i.x_high); uy_q[2] <= vert_u(in_item_i.y_low);
      ux_q[3] <= vert_u(in_item_i.x_high); uy_q[3] <= vert_u(in_item_i.y_high);
      ux_q[4] <= vert_u(in_item_i.x_low);  uy_q[4] <= vert_u(in_item_i.y_high);
    end
    if (lv_load) begin
      for (int i = 0; i <= 4; i++) h_q[i] <= h_new[i];
    end
    if (tri_new) pend_q <= new_job;
  end

  // no job may be left behind when a cell is done
  a_idle_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == F_IDLE |-> !pend_valid_q) else $error("job left pending at idle");
  // jobs leave only while walking triangles or flushing
  a_push_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push_o |-> (state_q == F_TRI || state_q == F_FLUSH))
    else $error("job pushed outside walk");

endmodule

FILE: hw/rtl/ccs_queue.sv
// Two-entry job queue between front end and back end.
// Uses job_t and queue sizes from ccs_pkg.
module ccs_queue import ccs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_data_i,
  output logic ready_o,
  input  logic pop_i,
  output job_t pop_data_o,
  output logic valid_o
);

  job_t                 mem_q [QueueDepth];
  logic [QueueAw-1:0]   wr_q, rd_q;
  logic [QueueAw:0]     cnt_q;

  assign ready_o    = (cnt_q != (QueueAw+1)'(QueueDepth));
  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = mem_q[rd_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + QueueAw'(1);
      if (pop_i) rd_q <= rd_q + QueueAw'(1);
      if (push_i && !pop_i) cnt_q <= cnt_q + (QueueAw+1)'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - (QueueAw+1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> ready_o) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o) else $error("queue underflow");

endmodule

FILE: hw/rtl/ccs_xing.sv
// Edge crossing unit: weighted mean of two positions by height magnitudes,
// shift-add multiply then restoring divide. Uses ccs_pkg.
module ccs_xing import ccs_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   start_i,
  input  xreq_t  req_i,
  output logic   done_o,
  output qwide_t result_o
);

  xing_state_e state_q, state_d;
  logic [MagW-1:0]     a_q, b_q;
  logic [SumW-1:0]     s_q;
  upos_t               ua_q, ub_q;
  logic [AccW-1:0]     acc_q;
  logic [DivW-1:0]     rem_q;
  logic [QuoW-1:0]     lo_q;
  logic [StepCntW-1:0] cnt_q;
  qwide_t              res_q;

  // combinational step values
  logic [SumW-1:0]  s_sum;
  logic [AccW-1:0]  acc_mul, acc_fin;
  logic [DivW:0]    trial, dvs;
  logic             ge;
  logic [DivW-1:0]  rem_nx;
  logic [QuoW-1:0]  lo_nx;
  logic             cnt_end;

  always_comb begin
    s_sum   = {1'b0, a_q} + {1'b0, b_q};
    acc_mul = {acc_q[AccW-2:0], 1'b0}
            + (ua_q[UposW-1] ? AccW'(b_q) : '0)
            + (ub_q[UposW-1] ? AccW'(a_q) : '0);
    acc_fin = acc_q + AccW'(s_q);
    dvs     = {1'b0, s_q, 1'b0};
    trial   = {rem_q, lo_q[QuoW-1]};
    ge      = (trial >= dvs);
    rem_nx  = ge ? DivW'(trial - dvs) : trial[DivW-1:0];
    lo_nx   = {lo_q[QuoW-2:0], ge};
    cnt_end = (cnt_q == StepCntW'(QuoW - 1));
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      X_IDLE: if (start_i) state_d = X_SUM;
      X_SUM:  state_d = (s_sum == '0) ? X_DONE : X_MUL;
      X_MUL:  if (cnt_end) state_d = X_ADD;
      X_ADD:  state_d = X_DIV;
      X_DIV:  if (cnt_end) state_d = X_DONE;
      X_DONE: state_d = X_IDLE;
      default: state_d = X_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    done_o   = (state_q == X_DONE);
    result_o = res_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= X_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == X_SUM || state_q == X_ADD) cnt_q <= '0;
      else if (state_q == X_MUL || state_q == X_DIV) cnt_q <= cnt_q + StepCntW'(1);
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      X_IDLE: begin
        if (start_i) begin
          a_q  <= mag36(req_i.ha);
          b_q  <= mag36(req_i.hb);
          ua_q <= req_i.ua;
          ub_q <= req_i.ub;
        end
      end
      X_SUM: begin
        s_q   <= s_sum;
        acc_q <= '0;
        res_q <= half_to_q(ua_q);
      end
      X_MUL: begin
        acc_q <= acc_mul;
        ua_q  <= {ua_q[UposW-2:0], 1'b0};
        ub_q  <= {ub_q[UposW-2:0], 1'b0};
      end
      X_ADD: begin
        rem_q <= acc_fin[AccW-1:QuoW];
        lo_q  <= acc_fin[QuoW-1:0];
      end
      X_DIV: begin
        rem_q <= rem_nx;
        lo_q  <= lo_nx;
        if (cnt_end) res_q <= $signed({1'b0, lo_nx}) - QOfs;
      end
      default: ;
    endcase
  end

endmodule

FILE: hw/rtl/ccs_back.sv
// Back end: takes jobs, resolves the four end point coordinates, drives the
// output register. Uses ccs_pkg and the ccs_xing crossing unit.
module ccs_back import ccs_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   q_valid_i,
  input  job_t   q_data_i,
  output logic   q_pop_o,
  output logic   x_start_o,
  output xreq_t  x_req_o,
  input  logic   x_done_i,
  input  qwide_t x_result_i,
  output logic   out_valid_o,
  input  logic   out_stall_i,
  output seg_t   out_item_o
);

  back_state_e state_q, state_d;
  job_t        job_q;
  logic [1:0]  step_q;
  logic signed [31:0] coord_q [4];
  logic        out_valid_q;
  seg_t        out_q;

  // endpoint and coordinate for the current step
  endpoint_t ep;
  upos_t     ua, ub;
  always_comb begin
    ep = step_q[1] ? job_q.ep_end : job_q.ep_start;
    ua = step_q[0] ? ep.uya : ep.uxa;
    ub = step_q[0] ? ep.uyb : ep.uxb;
    x_req_o = '{ha: ep.ha, hb: ep.hb, ua: ua, ub: ub};
  end

  logic out_free;
  assign out_free = !out_valid_q || !out_stall_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE: if (q_valid_i) state_d = B_EVAL;
      B_EVAL: begin
        if (ep.xing) state_d = B_WAIT;
        else if (step_q == 2'd3) state_d = B_OUT;
      end
      B_WAIT: begin
        if (x_done_i) state_d = (step_q == 2'd3) ? B_OUT : B_EVAL;
      end
      B_OUT:  if (out_free) state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  // control outputs
  logic store_vtx, store_x, load_out;
  always_comb begin
    q_pop_o   = (state_q == B_IDLE) && q_valid_i;
    x_start_o = (state_q == B_EVAL) && ep.xing;
    store_vtx = (state_q == B_EVAL) && !ep.xing;
    store_x   = (state_q == B_WAIT) && x_done_i;
    load_out  = (state_q == B_OUT) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (q_pop_o) step_q <= '0;
      else if (store_vtx || store_x) step_q <= step_q + 2'd1;
      if (load_out) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (q_pop_o) job_q <= q_data_i;
    if (store_vtx) coord_q[step_q] <= sat_q32(half_to_q(ua));
    if (store_x) coord_q[step_q] <= sat_q32(x_result_i);
    if (load_out) begin
      out_q.seg_x_start  <= coord_q[0];
      out_q.seg_y_start  <= coord_q[1];
      out_q.seg_x_end    <= coord_q[2];
      out_q.seg_y_end    <= coord_q[3];
      out_q.level_index  <= job_q.level;
      out_q.last_segment <= job_q.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // a crossing result only comes back while one is awaited
  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    x_done_i |-> state_q == B_WAIT) else $error("stray crossing result");

endmodule

FILE: verif/contour_cell_segmenter_top_tb.sv
// Self-checking testbench for contour_cell_segmenter_top: drives grid cells,
// predicts every contour segment in exact integer arithmetic and checks results.
// Depends on ccs_pkg and the RTL under hw/rtl.
`timescale 1ns / 100ps

module contour_cell_segmenter_top_tb;
  import ccs_pkg::*;

  localparam int unsigned WatchLimit = 40000;
  localparam logic [CfgIdxW-1:0] CfgSpareLo = 3'd5;
  localparam logic signed [63:0] QOffset = 64'sh1_0000_0000;
  localparam logic signed [63:0] HalfOffset = 64'sh2_0000_0000;

  // triangle case per class of (first, centre, next)
  localparam seg_case_e TriCase [3][3][3] = '{
    '{ '{SC_NONE, SC_NONE, SC_XCN_XNF},
       '{SC_NONE, SC_C_N, SC_C_XNF},
       '{SC_XFC_XCN, SC_N_XFC, SC_XNF_XFC} },
    '{ '{SC_NONE, SC_N_F, SC_F_XCN},
       '{SC_F_C, SC_N_F, SC_F_C},
       '{SC_F_XCN, SC_N_F, SC_NONE} },
    '{ '{SC_XNF_XFC, SC_N_XFC, SC_XFC_XCN},
       '{SC_C_XNF, SC_C_N, SC_NONE},
       '{SC_XCN_XNF, SC_NONE, SC_NONE} }
  };

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [31:0]        cfg_data_i;
  logic               in_valid_i;
  logic               in_stall_o;
  cell_t              in_item_i;
  logic               out_valid_o;
  logic               out_stall_i;
  seg_t               out_item_o;

  // shadow of the level registers
  logic [2:0]         level_count_q;
  logic signed [31:0] level_q [4];

  // per-cell working values of the segment predictor
  logic signed [63:0] rel_h [5];
  logic [63:0]        pos_x [5];
  logic [63:0]        pos_y [5];

  seg_t expected_segs [$];
  int   error_count;
  int   cells_sent;
  int   segs_checked;
  int   quiet_cycles;
  int   hold_left;
  bit   idle_on;

  contour_cell_segmenter_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  always #10 clk_i = ~clk_i;

  // ---------------------------------------------------------------- predictor
  function automatic logic signed [63:0] vtx_q(logic [63:0] u);
    return $signed((u + 64'd1) >> 1) - QOffset;
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fff_ffff;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic logic [127:0] mag128(logic signed [63:0] v);
    logic [63:0] m;
    m = v < 0 ? -v : v;
    return {64'd0, m};
  endfunction

  // weighted edge crossing between vertices pa and pb, one coordinate
  function automatic logic signed [63:0] cross_q(int pa, int pb, logic [63:0] ua,
                                                 logic [63:0] ub);
    logic [127:0] a, b, s, num, quo;
    a = mag128(rel_h[pa]);
    b = mag128(rel_h[pb]);
    s = a + b;
    if (s == 0) return vtx_q(ua);
    num = b * {64'd0, ua} + a * {64'd0, ub} + s;
    quo = num / (s << 1);
    return $signed(quo[63:0]) - QOffset;
  endfunction

  function automatic void vtx_pt(int p, output logic signed [63:0] x,
                                 output logic signed [63:0] y);
    x = vtx_q(pos_x[p]);
    y = vtx_q(pos_y[p]);
  endfunction

  function automatic void cross_pt(int pa, int pb, output logic signed [63:0] x,
                                   output logic signed [63:0] y);
    x = cross_q(pa, pb, pos_x[pa], pos_x[pb]);
    y = cross_q(pa, pb, pos_y[pa], pos_y[pb]);
  endfunction

  function automatic logic [1:0] height_class(logic signed [63:0] v);
    if (v > 0) return SH_ABOVE;
    if (v < 0) return SH_BELOW;
    return SH_ON;
  endfunction

  // all segments that one cell produces, appended to expected_segs
  function automatic void segment_cell(cell_t c);
    logic signed [63:0] lv [4];
    logic signed [63:0] d [5];
    logic signed [63:0] xl, xh, yl, yh, dmin, dmax, diff;
    logic signed [63:0] x1, y1, x2, y2;
    logic [1:0] cls [5];
    int nlev, n, v3;
    seg_t s;
    seg_case_e sc;
    for (int k = 0; k < 4; k++) lv[k] = level_q[k];
    nlev = level_count_q > 4 ? 4 : level_count_q;
    if (nlev == 0) return;
    d[1] = c.height_sw; d[2] = c.height_se; d[3] = c.height_ne; d[4] = c.height_nw;
    xl = c.x_low; xh = c.x_high; yl = c.y_low; yh = c.y_high;
    dmin = d[1]; dmax = d[1];
    for (int m = 2; m <= 4; m++) begin
      if (d[m] < dmin) dmin = d[m];
      if (d[m] > dmax) dmax = d[m];
    end
    if (dmax < lv[0] || dmin > lv[nlev-1]) return;
    pos_x[0] = xl + xh + HalfOffset;     pos_y[0] = yl + yh + HalfOffset;
    pos_x[1] = 2 * xl + HalfOffset;      pos_y[1] = 2 * yl + HalfOffset;
    pos_x[2] = 2 * xh + HalfOffset;      pos_y[2] = 2 * yl + HalfOffset;
    pos_x[3] = 2 * xh + HalfOffset;      pos_y[3] = 2 * yh + HalfOffset;
    pos_x[4] = 2 * xl + HalfOffset;      pos_y[4] = 2 * yh + HalfOffset;
    n = 0;
    for (int k = 0; k < nlev; k++) begin
      if (lv[k] < dmin || lv[k] > dmax) continue;
      rel_h[0] = 0;
      for (int m = 1; m <= 4; m++) begin
        diff = d[m] - lv[k];
        rel_h[m] = 4 * diff;
        rel_h[0] += diff;
      end
      for (int m = 0; m <= 4; m++) cls[m] = height_class(rel_h[m]);
      for (int m = 1; m <= 4; m++) begin
        v3 = (m == 4) ? 1 : m + 1;
        sc = TriCase[cls[m]][cls[0]][cls[v3]];
        case (sc)
          SC_F_C:     begin vtx_pt(m, x1, y1);       vtx_pt(0, x2, y2); end
          SC_C_N:     begin vtx_pt(0, x1, y1);       vtx_pt(v3, x2, y2); end
          SC_N_F:     begin vtx_pt(v3, x1, y1);      vtx_pt(m, x2, y2); end
          SC_F_XCN:   begin vtx_pt(m, x1, y1);       cross_pt(0, v3, x2, y2); end
          SC_C_XNF:   begin vtx_pt(0, x1, y1);       cross_pt(v3, m, x2, y2); end
          SC_N_XFC:   begin vtx_pt(v3, x1, y1);      cross_pt(m, 0, x2, y2); end
          SC_XFC_XCN: begin cross_pt(m, 0, x1, y1);  cross_pt(0, v3, x2, y2); end
          SC_XCN_XNF: begin cross_pt(0, v3, x1, y1); cross_pt(v3, m, x2, y2); end
          SC_XNF_XFC: begin cross_pt(v3, m, x1, y1); cross_pt(m, 0, x2, y2); end
          default: continue;
        endcase
        if (n >= 16) continue;
        s.seg_x_start  = sat32(x1);
        s.seg_y_start  = sat32(y1);
        s.seg_x_end    = sat32(x2);
        s.seg_y_end    = sat32(y2);
        s.level_index  = k[1:0];
        s.last_segment = 1'b0;
        expected_segs.push_back(s);
        n++;
      end
    end
    if (n > 0) expected_segs[$].last_segment = 1'b1;
  endfunction

  // ------------------------------------------------------------ result check
  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch seg %0d %s: got %h want %h", segs_checked, field, got, want);
    error_count++;
  endtask

  always @(posedge clk_i) begin
    seg_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_segs.size() == 0) begin
        report_mismatch("unexpected x_start", out_item_o.seg_x_start, 32'd0);
      end else begin
        want = expected_segs.pop_front();
        if (out_item_o.seg_x_start !== want.seg_x_start)
          report_mismatch("x_start", out_item_o.seg_x_start, want.seg_x_start);
        if (out_item_o.seg_y_start !== want.seg_y_start)
          report_mismatch("y_start", out_item_o.seg_y_start, want.seg_y_start);
        if (out_item_o.seg_x_end !== want.seg_x_end)
          report_mismatch("x_end", out_item_o.seg_x_end, want.seg_x_end);
        if (out_item_o.seg_y_end !== want.seg_y_end)
          report_mismatch("y_end", out_item_o.seg_y_end, want.seg_y_end);
        if (out_item_o.level_index !== want.level_index)
          report_mismatch("level_index", 32'(out_item_o.level_index),
                          32'(want.level_index));
        if (out_item_o.last_segment !== want.last_segment)
          report_mismatch("last_segment", 32'(out_item_o.last_segment),
                          32'(want.last_segment));
      end
      segs_checked++;
    end
  end

  // watchdog: cycles with no item moving on either side
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles = 0;
    end else if (rst_ni) begin
      quiet_cycles++;
      if (quiet_cycles >= WatchLimit) begin
        $display("watchdog expired with %0d segments pending", expected_segs.size());
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // receiver: random stalls plus a counted hold-off
  always @(negedge clk_i) begin
    if (hold_left > 0) hold_left--;
    out_stall_i = (hold_left > 0) || (idle_on && $urandom_range(99) < 22);
  end

  // --------------------------------------------------------------- stimulus
  task automatic send_cell(cell_t c);
    @(negedge clk_i);
    while (idle_on && $urandom_range(99) < 22) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_item_i  = c;
    do @(posedge clk_i); while (in_stall_o);
    segment_cell(c);
    cells_sent++;
  endtask

  // sender pause until every segment is back, then let the front settle
  task automatic drain_segments();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (expected_segs.size() > 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [31:0] data);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == CFG_LEVEL_COUNT) level_count_q = data[2:0];
    else if (idx >= CFG_LEVEL_ZERO && idx < CfgSpareLo) level_q[idx - CFG_LEVEL_ZERO] = data;
  endtask

  task automatic set_levels(logic [2:0] cnt, logic [31:0] l0, logic [31:0] l1,
                            logic [31:0] l2, logic [31:0] l3);
    drain_segments();
    write_reg(CFG_LEVEL_COUNT, {29'($urandom), cnt});
    write_reg(CFG_LEVEL_ZERO, l0);
    write_reg(CFG_LEVEL_ZERO + 3'd1, l1);
    write_reg(CFG_LEVEL_ZERO + 3'd2, l2);
    write_reg(CFG_LEVEL_ZERO + 3'd3, l3);
  endtask

  function automatic cell_t make_cell(logic [31:0] sw, logic [31:0] se, logic [31:0] ne,
                                      logic [31:0] nw, logic [31:0] xl, logic [31:0] xh,
                                      logic [31:0] yl, logic [31:0] yh);
    return '{sw, se, ne, nw, xl, xh, yl, yh};
  endfunction

  // height near one of the current levels, sometimes exactly on it, sometimes fully random
  function automatic logic [31:0] near_level();
    logic [31:0] base;
    base = level_q[$urandom_range(3)];
    case ($urandom_range(4))
      0: return base;
      1: return base + $urandom_range(2, 0) - 1;
      2: return $urandom;
      default: return base + $urandom_range(1 << 19) - (1 << 18);
    endcase
  endfunction

  function automatic cell_t random_cell();
    cell_t c;
    logic [31:0] xl, yl;
    if ($urandom_range(99) < 15) begin
      c = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    end else begin
      xl = $urandom_range(1 << 25) - (1 << 24);
      yl = $urandom_range(1 << 25) - (1 << 24);
      c = make_cell(near_level(), near_level(), near_level(), near_level(),
                    xl, xl + $urandom_range(1 << 20, 1), yl, yl + $urandom_range(1 << 20, 1));
    end
    return c;
  endfunction

  task automatic send_random(int count);
    for (int i = 0; i < count; i++) send_cell(random_cell());
  endtask

  // reset values: one level at zero; flat, mixed and extreme cells
  task automatic test_reset_levels();
    send_cell(make_cell(0, 0, 0, 0, 0, 32'h0001_0000, 0, 32'h0001_0000));
    send_cell(make_cell(32'h0001_0000, 32'hffff_0000, 32'h0002_0000, 32'hfffe_0000,
                        32'h0001_0000, 32'h0002_0000, 32'hffff_0000, 32'h0000_8001));
    send_cell(make_cell(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                        32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff));
    send_cell(make_cell(0, 32'h0000_0001, 0, 32'hffff_ffff,
                        32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000));
    send_cell(make_cell(0, 0, 32'h0003_0000, 32'hfffd_0000, 3, 7, 5, 9));
  endtask

  // count zero, saturating count and the spare register indexes
  task automatic test_level_count_edges();
    set_levels(3'd0, 0, 0, 0, 0);
    send_cell(make_cell(32'hffff_0000, 32'h0001_0000, 0, 0, 0, 32'h10000, 0, 32'h10000));
    set_levels(3'd7, 32'hfffe_0000, 32'hffff_0000, 32'h0001_0000, 32'h0002_0000);
    for (logic [CfgIdxW-1:0] i = CfgSpareLo; i != 0; i++) write_reg(i, $urandom);
    send_cell(make_cell(32'hfffd_0000, 32'h0003_0000, 32'hfffc_0000, 32'h0004_0000,
                        0, 32'h0004_0000, 0, 32'h0004_0000));
    send_cell(make_cell(32'hfffe_0000, 32'hffff_0000, 32'h0001_0000, 32'h0002_0000,
                        32'h10, 32'h20, 32'h30, 32'h40));
  endtask

  // cells wholly below or above the levels, and single levels out of range
  task automatic test_out_of_range();
    set_levels(3'd4, 32'hfffe_0000, 32'hffff_0000, 32'h0001_0000, 32'h0002_0000);
    send_cell(make_cell(32'hfff0_0000, 32'hfff1_0000, 32'hfff2_0000, 32'hfffd_ffff,
                        0, 32'h10000, 0, 32'h10000));
    send_cell(make_cell(32'h0002_0001, 32'h0003_0000, 32'h0005_0000, 32'h0009_0000,
                        0, 32'h10000, 0, 32'h10000));
    send_cell(make_cell(32'h0000_8000, 32'h0001_8000, 32'h0001_0000, 32'h0000_4000,
                        0, 32'h10000, 0, 32'h10000));
    send_cell(make_cell(32'hfffe_0000, 32'hfffe_0000, 32'hfffe_0000, 32'hfffe_0000,
                        0, 32'h10000, 0, 32'h10000));
  endtask

  // levels out of order: the cell-wide test uses the first and last level only
  task automatic test_unordered_levels();
    set_levels(3'd3, 32'h0004_0000, 32'hfffc_0000, 32'h0000_0000, 32'h7fff_ffff);
    send_cell(make_cell(32'hffff_0000, 32'h0001_0000, 32'hfffb_0000, 32'h0005_0000,
                        0, 32'h10000, 0, 32'h10000));
    send_cell(make_cell(32'h0005_0000, 32'h0006_0000, 32'h0007_0000, 32'h0008_0000,
                        0, 32'h10000, 0, 32'h10000));
    send_cell(make_cell(32'hfff0_0000, 32'hfff0_0000, 32'hffff_0000, 32'hfff0_0000,
                        0, 32'h10000, 0, 32'h10000));
  endtask

  // random cells across several level settings, including the extremes
  task automatic test_random_settings();
    set_levels(3'd4, 32'hffff_0000, 0, 32'h0001_0000, 32'h0003_0000);
    send_random(40);
    set_levels(3'd1, 32'h7fff_ffff, $urandom, $urandom, $urandom);
    send_random(15);
    set_levels(3'd2, 32'h8000_0000, 32'h8000_0001, $urandom, $urandom);
    send_random(15);
    set_levels(3'd5, $urandom_range(1 << 16) - (1 << 15), 32'h0000_8000, 32'h0002_0000,
               32'h7fff_ffff);
    idle_on = 1'b0;
    send_random(40);
    idle_on = 1'b1;
  endtask

  // long receiver hold-off while cells keep coming, so the input stalls
  task automatic test_backpressure();
    set_levels(3'd4, 32'hfffe_0000, 32'hffff_8000, 32'h0000_8000, 32'h0002_0000);
    hold_left = 600;
    send_random(30);
    drain_segments();
    send_random(60);
  endtask

  initial begin
    clk_i = 1'b0; rst_ni = 1'b0;
    cfg_we_i = 1'b0; cfg_index_i = '0; cfg_data_i = '0;
    in_valid_i = 1'b0; in_item_i = '0;
    level_count_q = 3'd1;
    for (int k = 0; k < 4; k++) level_q[k] = '0;
    error_count = 0; cells_sent = 0; segs_checked = 0; quiet_cycles = 0;
    hold_left = 0; idle_on = 1'b1;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_levels();
    test_level_count_edges();
    test_out_of_range();
    test_unordered_levels();
    test_random_settings();
    test_backpressure();
    drain_segments();

    $display("covered %0d cells and %0d segments over level counts 0..7,", cells_sent,
             segs_checked);
    $display("extreme levels and heights, stalls on both sides and a long hold-off");
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
